// ===== hw/rtl/iec_pkg.sv =====
package iec_pkg;

    localparam int DATA_W     = 16;
    localparam int WIDE_W     = 17;
    localparam int ACC_W      = 36;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_DZ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] QUAT_LIMIT_RST  = 15'd16;
    localparam logic [CFG_DATA_W-1:0] ACCEL_DZ_RST    = 15'd8;
    localparam logic [CFG_DATA_W-1:0] ACCEL_LIMIT_RST = 15'd16;

    // unit quaternion real part in Q2.14
    localparam logic signed [DATA_W-1:0] QUAT_ONE = 16'sd16384;

    localparam logic KIND_QUAT  = 1'b0;
    localparam logic KIND_ACCEL = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] w_val;
        logic signed [DATA_W-1:0] x_val;
        logic signed [DATA_W-1:0] y_val;
        logic signed [DATA_W-1:0] z_val;
    } iec_in_t;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] w_out;
        logic signed [DATA_W-1:0] x_out;
        logic signed [DATA_W-1:0] y_out;
        logic signed [DATA_W-1:0] z_out;
        logic                     changed;
    } iec_out_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
    } mac_ctl_t;

endpackage

// ===== hw/rtl/iec_in_if.sv =====
interface iec_in_if;
    logic             valid;
    logic             ready;
    iec_pkg::iec_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/iec_out_if.sv =====
interface iec_out_if;
    logic              valid;
    logic              ready;
    iec_pkg::iec_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/imu_event_conditioner.sv =====
// Quaternion event: steps from input transfer to result valid
//   (4 dot-product steps, sign fix, limit square, 4 distance steps, result).
// Acceleration event: one axis per cycle, then result.
// One shared 17x17 MAC unit, one item at a time.
// Reset: kept and reported quaternions to (1,0,0,0), reported accel to zero,
//   registers to 16 / 8 / 16, no result pending.
module imu_event_conditioner (
    input  logic                               clk,
    input  logic                               rst_n,
    iec_in_if.sink                             in_ch,
    iec_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [iec_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [iec_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import iec_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DOT  = 3'd1;
    localparam logic [2:0] S_FLIP = 3'd2;
    localparam logic [2:0] S_LIM  = 3'd3;
    localparam logic [2:0] S_DIST = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    function automatic logic signed [WIDE_W-1:0] sx(input logic signed [DATA_W-1:0] v);
        sx = {v[DATA_W-1], v};
    endfunction

    function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        r = -v;
        if (v == {1'b1, {(DATA_W-1){1'b0}}})
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        neg_sat = r;
    endfunction

    logic [2:0]                state_reg, state_next;
    logic [1:0]                idx_reg, idx_next;
    logic                      kind_reg, kind_next;
    logic                      chg_reg, chg_next;
    logic signed [DATA_W-1:0]  q_reg [4];
    logic signed [DATA_W-1:0]  q_next [4];
    logic signed [DATA_W-1:0]  last_reg [4];
    logic signed [DATA_W-1:0]  last_next [4];
    logic signed [DATA_W-1:0]  rep_q_reg [4];
    logic signed [DATA_W-1:0]  rep_q_next [4];
    logic signed [DATA_W-1:0]  rep_a_reg [3];
    logic signed [DATA_W-1:0]  rep_a_next [3];
    logic [CFG_DATA_W-1:0]     qlim_reg, dz_reg, alim_reg;
    iec_out_t                  out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    mac_ctl_t                  mac_ctl;
    logic signed [WIDE_W-1:0]  mac_a, mac_b;
    logic signed [ACC_W-1:0]   acc;

    logic                      in_fire;
    logic                      out_fire;
    logic                      flip;
    logic                      dist_over;
    logic signed [WIDE_W-1:0]  d_val;
    logic [1:0]                aidx;
    logic signed [DATA_W-1:0]  ax;
    logic signed [WIDE_W-1:0]  ax_w;
    logic [WIDE_W-1:0]         mag;
    logic signed [DATA_W-1:0]  a_dz;
    logic signed [WIDE_W-1:0]  adiff;
    logic [WIDE_W-1:0]         adabs;

    iec_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (mac_a),
        .b   (mac_b),
        .acc (acc)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
    assign out_fire     = out_valid_reg && out_ch.ready;

    assign flip      = acc[ACC_W-1];
    // accumulator holds dist^2 - limit^2
    assign dist_over = !acc[ACC_W-1] && (acc != '0);
    assign d_val     = sx(q_reg[idx_reg]) - sx(rep_q_reg[idx_reg]);

    // acceleration datapath, one axis per cycle
    assign aidx  = idx_reg + 2'd1;
    assign ax    = q_reg[aidx];
    assign ax_w  = sx(ax);
    assign mag   = ax[DATA_W-1] ? WIDE_W'(-ax_w) : WIDE_W'(ax_w);
    assign a_dz  = (mag < {2'b00, dz_reg}) ? '0 : ax;
    assign adiff = sx(a_dz) - sx(rep_a_reg[idx_reg]);
    assign adabs = adiff[WIDE_W-1] ? WIDE_W'(-adiff) : WIDE_W'(adiff);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        chg_next       = chg_reg;
        q_next         = q_reg;
        last_next      = last_reg;
        rep_q_next     = rep_q_reg;
        rep_a_next     = rep_a_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mac_ctl        = '0;
        mac_a          = '0;
        mac_b          = '0;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next = in_ch.data.command;
                    q_next[0] = in_ch.data.w_val;
                    q_next[1] = in_ch.data.x_val;
                    q_next[2] = in_ch.data.y_val;
                    q_next[3] = in_ch.data.z_val;
                    chg_next  = 1'b0;
                    idx_next  = '0;
                    state_next = (in_ch.data.command == KIND_ACCEL) ? S_ACC : S_DOT;
                end
            end
            S_DOT:
            begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = (idx_reg == 2'd0);
                mac_a       = sx(q_reg[idx_reg]);
                mac_b       = sx(last_reg[idx_reg]);
                idx_next    = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = S_FLIP;
                end
            end
            S_FLIP:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    q_next[i]    = flip ? neg_sat(q_reg[i]) : q_reg[i];
                    last_next[i] = q_next[i];
                end
                state_next = S_LIM;
            end
            S_LIM:
            begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_ctl.sub = 1'b1;
                mac_a       = {2'b00, qlim_reg};
                mac_b       = {2'b00, qlim_reg};
                idx_next    = '0;
                state_next  = S_DIST;
            end
            S_DIST:
            begin
                mac_ctl.en = 1'b1;
                mac_a      = d_val;
                mac_b      = d_val;
                idx_next   = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    state_next = S_DONE;
                end
            end
            S_ACC:
            begin
                q_next[aidx] = a_dz;
                if (adabs >= {2'b00, alim_reg})
                begin
                    chg_next = 1'b1;
                end
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait here while the previous result is still unclaimed
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.kind  = kind_reg;
                    out_next.x_out = q_reg[1];
                    out_next.y_out = q_reg[2];
                    out_next.z_out = q_reg[3];
                    if (kind_reg == KIND_ACCEL)
                    begin
                        out_next.w_out   = '0;
                        out_next.changed = chg_reg;
                        if (chg_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                rep_a_next[i] = q_reg[i+1];
                            end
                        end
                    end
                    else
                    begin
                        out_next.w_out   = q_reg[0];
                        out_next.changed = dist_over;
                        if (dist_over)
                        begin
                            rep_q_next = q_reg;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            qlim_reg      <= QUAT_LIMIT_RST;
            dz_reg        <= ACCEL_DZ_RST;
            alim_reg      <= ACCEL_LIMIT_RST;
            for (int i = 0; i < 4; i++)
            begin
                last_reg[i]  <= (i == 0) ? QUAT_ONE : '0;
                rep_q_reg[i] <= (i == 0) ? QUAT_ONE : '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                rep_a_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            rep_q_reg     <= rep_q_next;
            rep_a_reg     <= rep_a_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_QUAT_LIMIT:  qlim_reg <= cfg_wdata;
                    CFG_ACCEL_DZ:    dz_reg   <= cfg_wdata;
                    CFG_ACCEL_LIMIT: alim_reg <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        chg_reg  <= chg_next;
        q_reg    <= q_next;
        out_reg  <= out_next;
    end

endmodule

// ===== hw/rtl/iec_mac.sv =====
module iec_mac (
    input  logic                                   clk,
    input  iec_pkg::mac_ctl_t                      ctl,
    input  logic signed [iec_pkg::WIDE_W-1:0]      a,
    input  logic signed [iec_pkg::WIDE_W-1:0]      b,
    output logic signed [iec_pkg::ACC_W-1:0]       acc
);
    import iec_pkg::*;

    logic signed [2*WIDE_W-1:0] prod;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    base;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;

    assign prod     = a * b;
    assign prod_ext = ACC_W'(prod);
    assign base     = ctl.clr ? '0 : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.en)
        begin
            acc_next = ctl.sub ? (base - prod_ext) : (base + prod_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== bench/imu_event_conditioner_tb.sv =====
`timescale 1ns / 1ps

module imu_event_conditioner_tb;
    import iec_pkg::*;

    localparam int NUM_DIRECTED     = 20;
    localparam int PHASES           = 6;
    localparam int EVENTS_PER_PHASE = 190;
    localparam int STALL_LIMIT      = 3000;
    localparam int DRAIN_CYCLES     = 20;
    // unmapped register index, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic     typed;
        iec_in_t  ev;
        iec_out_t res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    iec_in_if  in_ch ();
    iec_out_if out_ch ();

    imu_event_conditioner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state and register copies
    int kept_q [4];
    int ref_q [4];
    int ref_acc [3];
    int quat_lim;
    int dead_zone;
    int accel_lim;

    iec_out_t pending_results [$];
    int fail_count = 0;
    int stall_count = 0;
    int src_idle_pct = 33;
    int sink_idle_pct = 85;

    // expected values typed in only where they follow directly from reset state
    dir_row_t dir_tab [0:NUM_DIRECTED-1] = '{
        '{1'b1, '{KIND_QUAT, 16384, 0, 0, 0}, '{KIND_QUAT, 16384, 0, 0, 0, 1'b0}},
        '{1'b1, '{KIND_QUAT, -16384, 0, 0, 0}, '{KIND_QUAT, 16384, 0, 0, 0, 1'b0}},
        '{1'b1, '{KIND_QUAT, 0, 16384, 0, 0}, '{KIND_QUAT, 0, 16384, 0, 0, 1'b1}},
        '{1'b1, '{KIND_QUAT, -32768, -32768, -32768, -32768},
                '{KIND_QUAT, 32767, 32767, 32767, 32767, 1'b1}},
        '{1'b1, '{KIND_QUAT, 32767, 32767, 32767, 32767},
                '{KIND_QUAT, 32767, 32767, 32767, 32767, 1'b0}},
        '{1'b1, '{KIND_QUAT, 0, 0, 0, 0}, '{KIND_QUAT, 0, 0, 0, 0, 1'b1}},
        '{1'b1, '{KIND_QUAT, 0, 16, 0, 0}, '{KIND_QUAT, 0, 16, 0, 0, 1'b0}},
        '{1'b1, '{KIND_QUAT, 0, 16, 1, 0}, '{KIND_QUAT, 0, 16, 1, 0, 1'b1}},
        '{1'b1, '{KIND_QUAT, 0, -16, -1, 0}, '{KIND_QUAT, 0, 16, 1, 0, 1'b0}},
        '{1'b0, '{KIND_QUAT, -32768, 32767, -1, 1}, '0},
        '{1'b1, '{KIND_ACCEL, 1234, 7, -7, 8}, '{KIND_ACCEL, 0, 0, 0, 8, 1'b0}},
        '{1'b1, '{KIND_ACCEL, -1, -32768, 32767, -8},
                '{KIND_ACCEL, 0, -32768, 32767, -8, 1'b1}},
        '{1'b1, '{KIND_ACCEL, 32767, -32753, 32752, 7},
                '{KIND_ACCEL, 0, -32753, 32752, 0, 1'b0}},
        '{1'b1, '{KIND_ACCEL, -32768, -32752, 32767, -8},
                '{KIND_ACCEL, 0, -32752, 32767, -8, 1'b1}},
        '{1'b0, '{KIND_QUAT, 16384, -1, 1, -32768}, '0},
        '{1'b0, '{KIND_ACCEL, 0, 0, 0, 0}, '0},
        '{1'b0, '{KIND_ACCEL, -32768, -8, 8, -7}, '0},
        '{1'b0, '{KIND_QUAT, -1, -1, -1, -1}, '0},
        '{1'b0, '{KIND_QUAT, 32767, -32768, 32767, -32768}, '0},
        '{1'b0, '{KIND_ACCEL, 21845, -21846, 21845, -1}, '0}
    };

    always #5 clk = ~clk;

    function automatic int sat16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // sign continuity, deadzone and change detection; updates the predictor state
    function automatic iec_out_t condition_event(input iec_in_t ev);
        iec_out_t res;
        int comp [4];
        int acc [3];
        longint dot;
        longint dist_sq;
        longint d;
        logic hit;
        comp[0] = ev.w_val;
        comp[1] = ev.x_val;
        comp[2] = ev.y_val;
        comp[3] = ev.z_val;
        res = '0;
        res.kind = ev.command;
        hit = 1'b0;
        if (ev.command == KIND_QUAT)
        begin
            dot = 0;
            for (int i = 0; i < 4; i++)
                dot += longint'(comp[i]) * longint'(kept_q[i]);
            if (dot < 0)
            begin
                for (int i = 0; i < 4; i++)
                    comp[i] = sat16(-comp[i]);
            end
            dist_sq = 0;
            for (int i = 0; i < 4; i++)
            begin
                d = comp[i] - ref_q[i];
                dist_sq += d * d;
                kept_q[i] = comp[i];
            end
            hit = dist_sq > longint'(quat_lim) * longint'(quat_lim);
            if (hit)
                ref_q = comp;
            res.w_out = DATA_W'(comp[0]);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc[i] = comp[i + 1];
                if (magnitude(acc[i]) < dead_zone)
                    acc[i] = 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (magnitude(acc[i] - ref_acc[i]) >= accel_lim)
                    hit = 1'b1;
            end
            if (hit)
                ref_acc = acc;
            for (int i = 0; i < 3; i++)
                comp[i + 1] = acc[i];
        end
        res.x_out = DATA_W'(comp[1]);
        res.y_out = DATA_W'(comp[2]);
        res.z_out = DATA_W'(comp[3]);
        res.changed = hit;
        return res;
    endfunction

    // mostly small walks around the current state, plus flips, extremes and noise
    function automatic iec_in_t make_event();
        iec_in_t ev;
        int comp [4];
        int pick;
        pick = $urandom_range(99);
        for (int i = 0; i < 4; i++)
            comp[i] = int'($urandom_range(65535)) - 32768;
        ev.command = (pick < 60) ? KIND_QUAT : KIND_ACCEL;
        if (pick < 45)
        begin
            for (int i = 0; i < 4; i++)
                comp[i] = sat16(kept_q[i] + jitter(quat_lim / 2 + 4));
            if ($urandom_range(3) == 0)
            begin
                for (int i = 0; i < 4; i++)
                    comp[i] = sat16(-comp[i]);
            end
        end
        else if (pick >= 55 && pick < 60)
        begin
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(5))
                    0: comp[i] = -32768;
                    1: comp[i] = 32767;
                    2: comp[i] = 0;
                    3: comp[i] = -1;
                    4: comp[i] = 16384;
                    default: comp[i] = -16384;
                endcase
            end
        end
        else if (pick >= 60 && pick < 85)
        begin
            for (int i = 1; i < 4; i++)
            begin
                case ($urandom_range(4))
                    0, 1: comp[i] = sat16(ref_acc[i - 1] + jitter(accel_lim + 4));
                    2, 3: comp[i] = sat16(jitter(dead_zone + 2));
                    default: ;
                endcase
            end
        end
        ev.w_val = DATA_W'(comp[0]);
        ev.x_val = DATA_W'(comp[1]);
        ev.y_val = DATA_W'(comp[2]);
        ev.z_val = DATA_W'(comp[3]);
        return ev;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input iec_in_t ev, input logic typed, input iec_out_t typed_res);
        iec_out_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= ev;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = condition_event(ev);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    task automatic program_regs(input int qlim, input int dz, input int alim);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_QUAT_LIMIT;
        cfg_wdata <= CFG_DATA_W'(qlim);
        @(negedge clk);
        cfg_addr <= CFG_ACCEL_DZ;
        cfg_wdata <= CFG_DATA_W'(dz);
        @(negedge clk);
        cfg_addr <= CFG_ACCEL_LIMIT;
        cfg_wdata <= CFG_DATA_W'(alim);
        @(negedge clk);
        cfg_addr <= CFG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        quat_lim = qlim;
        dead_zone = dz;
        accel_lim = alim;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
    begin : result_check
        iec_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, out_ch.data);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, out_ch.data.kind);
                check_field("w_out", want.w_out, out_ch.data.w_out);
                check_field("x_out", want.x_out, out_ch.data.x_out);
                check_field("y_out", want.y_out, out_ch.data.y_out);
                check_field("z_out", want.z_out, out_ch.data.z_out);
                check_field("changed", want.changed, out_ch.data.changed);
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("imu_event_conditioner test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_QUAT_LIMIT;
        cfg_wdata = '0;
        quat_lim = QUAT_LIMIT_RST;
        dead_zone = ACCEL_DZ_RST;
        accel_lim = ACCEL_LIMIT_RST;
        kept_q = '{int'(QUAT_ONE), 0, 0, 0};
        ref_q = '{int'(QUAT_ONE), 0, 0, 0};
        ref_acc = '{0, 0, 0};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < NUM_DIRECTED; r++)
            send_item(dir_tab[r].ev, dir_tab[r].typed, dir_tab[r].res);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: program_regs(0, 0, 0);
                1: program_regs(32767, 32767, 32767);
                2: program_regs($urandom_range(400), $urandom_range(200), $urandom_range(300));
                3: program_regs($urandom_range(32767), $urandom_range(32767),
                                $urandom_range(32767));
                4: program_regs(1, 1, 1);
                default: program_regs(200, 64, 128);
            endcase
            case (ph / 2)
                0:
                begin
                    src_idle_pct = 33;
                    sink_idle_pct = 85;
                end
                1:
                begin
                    src_idle_pct = 85;
                    sink_idle_pct = 33;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < EVENTS_PER_PHASE; n++)
            begin
                // occasionally hold off until the pipeline is empty
                if ($urandom_range(49) == 0)
                    drain_results();
                send_item(make_event(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("imu_event_conditioner test passed");
        else
            $display("imu_event_conditioner test failed");
        $finish;
    end

endmodule
